@@ hw/rtl/tpq_pkg.sv @@
// Shared constants, codes and control types of the timestamp priority queue.
`default_nettype none

package tpq_pkg;

  localparam int SLOTS     = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int ID_W      = 4;
  localparam int TIME_W    = 15;
  localparam int COUNT_W   = 5;
  localparam int STATUS_W  = 3;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_ZERO_TIME = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_MISMATCH  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_FIRST,
    ST_APPLY,
    ST_SCAN_SECOND,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic scan_start;
    logic scan_step;
    logic apply;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpq_datapath.sv @@
// Slot table, scan trackers and output register of the timestamp priority queue.
`default_nettype none

module tpq_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tpq_pkg::cmd_t              cmd,
  output tpq_pkg::stat_t                  stat,
  input  wire logic [tpq_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [tpq_pkg::M_TDATA_W-1:0]   m_tdata
);
  import tpq_pkg::*;

  logic [TIME_W-1:0]  slot_time  [SLOTS];
  logic [ID_W-1:0]    slot_owner [SLOTS];
  logic [COUNT_W-1:0] occupied_count;

  func_t              op_func;
  logic [ID_W-1:0]    op_id;
  logic [TIME_W-1:0]  op_time;
  status_t            op_status;

  logic [IDX_W-1:0]   idx;
  logic               best_valid;
  logic [IDX_W-1:0]   best_idx;
  logic [TIME_W-1:0]  best_time;
  logic [ID_W-1:0]    best_id;
  logic               free_valid;
  logic [IDX_W-1:0]   free_idx;

  logic [TIME_W-1:0]  cur_time;
  logic [ID_W-1:0]    cur_id;
  logic               cur_better;

  assign cur_time = slot_time[idx];
  assign cur_id   = slot_owner[idx];

  // An occupied slot beats the current best on a smaller timestamp, or on a smaller id at a tie.
  assign cur_better = (cur_time != '0) &&
                      (!best_valid || (cur_time < best_time) ||
                       ((cur_time == best_time) && (cur_id < best_id)));

  assign stat.scan_last = (idx == IDX_W'(SLOTS - 1));
  assign stat.out_busy  = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_func <= func_t'(s_tuser);
      op_id   <= s_tdata[ID_W-1:0];
      op_time <= s_tdata[ID_W +: TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      best_valid <= 1'b0;
      free_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      idx        <= '0;
      best_valid <= 1'b0;
      free_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + IDX_W'(1);
      if (cur_better) begin
        best_valid <= 1'b1;
        best_idx   <= idx;
        best_time  <= cur_time;
        best_id    <= cur_id;
      end
      if ((cur_time == '0) && !free_valid) begin
        free_valid <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_time[i]  <= '0;
        slot_owner[i] <= '0;
      end
      occupied_count <= '0;
      op_status      <= STAT_OK;
    end else if (cmd.apply) begin
      op_status <= STAT_OK;
      if (op_func == FUNC_PUSH) begin
        if (op_time == '0) begin
          op_status <= STAT_ZERO_TIME;
        end else if (!free_valid) begin
          op_status <= STAT_FULL;
        end else begin
          slot_time[free_idx]  <= op_time;
          slot_owner[free_idx] <= op_id;
          occupied_count       <= occupied_count + COUNT_W'(1);
        end
      end else begin
        if (!best_valid) begin
          op_status <= STAT_EMPTY;
        end else if (best_id != op_id) begin
          op_status <= STAT_MISMATCH;
        end else begin
          slot_time[best_idx]  <= '0;
          slot_owner[best_idx] <= '0;
          occupied_count       <= occupied_count - COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Head fields read as zero when the second scan found no occupied slot.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {4'b0000,
                  op_status,
                  occupied_count,
                  !best_valid,
                  best_valid ? best_time : TIME_W'(0),
                  best_valid ? best_id : ID_W'(0)};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tpq_ctrl.sv @@
// Controller state machine that sequences the scans and the table update.
`default_nettype none

module tpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire tpq_pkg::stat_t stat,
  output tpq_pkg::cmd_t       cmd
);
  import tpq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.in_load    = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN_FIRST;
        end
      end
      ST_SCAN_FIRST: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply      = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN_SECOND;
      end
      ST_SCAN_SECOND: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/timestamp_priority_queue.sv @@
// Top level of the timestamp priority queue: controller and datapath.
// m_tvalid rises after two sequential scans over the slot table, one slot per cycle:
// the first finds a free slot or the head, then the table is updated and the second finds the new head.
// A new beat is taken only while idle, but it is taken while a result waits.
// Reset (rst, synchronous, active high) frees every slot and clears the count.
`default_nettype none

module timestamp_priority_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [3:0] entry_id, [18:4] entry_time, [23:19] zero
  input  wire logic [tpq_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] func
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [3:0] head_id, [18:4] head_time, [19] queue_empty, [24:20] entry_count,
  // [27:25] status, [31:28] zero
  output logic [tpq_pkg::M_TDATA_W-1:0]      m_tdata
);
  import tpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
